FILE: design/aiic_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive integer interval coder package
// Shared constants, row type and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package aiic_pkg;

  localparam int BUCKET_COUNT = 64;
  localparam int COUNT_WIDTH  = 16;
  localparam int CHUNK_BITS   = 16;

  // Counts are held four to a memory row, so a scan step adds up to four of them.
  localparam int LANES  = 4;
  localparam int ROWS   = BUCKET_COUNT / LANES;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int LANE_W = $clog2(LANES);
  localparam int SLOT_W = $clog2(BUCKET_COUNT);

  localparam int TOTAL_W = 23;  // running sum of all counts
  localparam int FIELD_W = 22;  // width of each interval bound
  localparam int SIG_W   = 5;   // significant-bit count, 0 to 31
  localparam int VALUE_W = 32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {COUNT_WIDTH{1'b1}};
  localparam logic [SIG_W-1:0]       CHUNK_MAX   = SIG_W'(CHUNK_BITS);

  typedef logic [LANES-1:0][COUNT_WIDTH-1:0] row_t;

  typedef struct packed {
    logic load;         // capture the accepted word
    logic prep;         // find the bucket, clear the sum
    logic scan;         // read the next row of counts
    logic bump;         // increment the bucket count unless saturated and write the row back
    logic emit_bucket;  // load the bucket interval into the output register
    logic emit_raw;     // load the next raw chunk into the output register
  } aiic_cmd_t;

  typedef struct packed {
    logic scan_last;    // the row being read holds the bucket
    logic sig_zero;     // no raw bits follow the bucket interval
    logic op_tally;     // tally only, nothing is emitted
    logic out_free;     // the output register can take a word this cycle
    logic raw_last;     // the current raw chunk is the final one
  } aiic_status_t;

endpackage

`default_nettype wire

FILE: design/aiic_ctrl.sv
// ----------------------------------------------------------------------------
// Adaptive integer interval coder controller
// Sequences one input word through bucket search, count scan, count update
// and, for encode words, the emission of the bucket and raw intervals.
// ----------------------------------------------------------------------------
`default_nettype none

module aiic_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  aiic_pkg::aiic_status_t   status,
  output aiic_pkg::aiic_cmd_t      cmd
);
  import aiic_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_BUCKET = 3'd4;
  localparam logic [2:0] S_RAW    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.bump   = 1'b1;
        state_next = status.op_tally ? S_IDLE : S_BUCKET;
      end
      S_BUCKET: begin
        if (status.out_free) begin
          cmd.emit_bucket = 1'b1;
          state_next      = status.sig_zero ? S_IDLE : S_RAW;
        end
      end
      S_RAW: begin
        if (status.out_free) begin
          cmd.emit_raw = 1'b1;
          if (status.raw_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/aiic_datapath.sv
// ----------------------------------------------------------------------------
// Adaptive integer interval coder datapath
// Count memory with row valid bits, prefix-sum accumulator, raw chunk
// splitter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aiic_datapath (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_opcode,
  input  wire  [aiic_pkg::VALUE_W-1:0]  in_value,
  input  aiic_pkg::aiic_cmd_t           cmd,
  output aiic_pkg::aiic_status_t        status,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [aiic_pkg::FIELD_W-1:0]  out_low,
  output logic [aiic_pkg::FIELD_W-1:0]  out_high,
  output logic [aiic_pkg::FIELD_W-1:0]  out_total,
  output logic                          out_last
);
  import aiic_pkg::*;

  // Captured word and its bucket.
  logic               op_tally;
  logic [VALUE_W-1:0] value;
  logic [SIG_W-1:0]   sig;
  logic [SLOT_W-1:0]  slot;
  logic [SIG_W-1:0]   left;
  logic [VALUE_W-1:0] rest;

  // Count store.
  row_t            mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [TOTAL_W-1:0] count_total;

  // Scan pipeline.
  logic [ROW_W-1:0]   row;
  row_t               rd_data;
  logic               rd_valid_row;
  logic               rd_vld;
  logic [ROW_W-1:0]   rd_row;
  logic [TOTAL_W-1:0] sum;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [TOTAL_W-1:0] total_snap;

  logic [VALUE_W-1:0] mag;
  logic [SIG_W-1:0]   sig_calc;
  row_t               eff;
  logic [TOTAL_W-1:0] row_part;
  row_t               wr_row;
  logic               can_inc;
  logic [SIG_W-1:0]   chunk;
  logic [VALUE_W-1:0] chunk_mask;

  wire [ROW_W-1:0]  slot_row  = slot[SLOT_W-1:LANE_W];
  wire [LANE_W-1:0] slot_lane = slot[LANE_W-1:0];

  // Bit length of the magnitude; bit 31 of the magnitude is always clear.
  always_comb begin
    mag      = value[VALUE_W-1] ? ~value : value;
    sig_calc = '0;
    for (int i = 0; i < VALUE_W - 1; i++) begin
      if (mag[i]) begin
        sig_calc = SIG_W'(i + 1);
      end
    end
  end

  // A row never written reads as the reset count of one in every lane.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      eff[l] = rd_valid_row ? rd_data[l] : COUNT_WIDTH'(1);
    end
    row_part = '0;
    for (int l = 0; l < LANES; l++) begin
      if (rd_row < slot_row || (rd_row == slot_row && LANE_W'(l) < slot_lane)) begin
        row_part = row_part + TOTAL_W'(eff[l]);
      end
    end
    can_inc = eff[slot_lane] < COUNT_LIMIT;
    wr_row  = eff;
    if (can_inc) begin
      wr_row[slot_lane] = eff[slot_lane] + COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    chunk      = (left > CHUNK_MAX) ? CHUNK_MAX : left;
    chunk_mask = ~({VALUE_W{1'b1}} << chunk);
  end

  always_comb begin
    status.scan_last = (row == slot_row);
    status.sig_zero  = (sig == '0);
    status.op_tally  = op_tally;
    status.out_free  = !out_valid || out_ready;
    status.raw_last  = (left <= CHUNK_MAX);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_tally <= in_opcode;
      value    <= in_value;
    end
    if (cmd.prep) begin
      sig  <= sig_calc;
      slot <= {value[VALUE_W-1], sig_calc};
      left <= sig_calc - SIG_W'(1);
      rest <= mag;
      row  <= '0;
      sum  <= '0;
    end
    if (cmd.scan) begin
      rd_data      <= mem[row];
      rd_valid_row <= row_valid[row];
      rd_row       <= row;
      row          <= row + ROW_W'(1);
    end
    if (rd_vld) begin
      sum <= sum + row_part;
      if (rd_row == slot_row) begin
        cnt <= eff[slot_lane];
      end
    end
    if (cmd.bump) begin
      mem[slot_row] <= wr_row;
      total_snap    <= count_total;
    end
    if (cmd.emit_raw) begin
      rest <= rest >> chunk;
      left <= left - chunk;
    end
  end

  // Control state of the store and the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid   <= '0;
      count_total <= TOTAL_W'(BUCKET_COUNT);
      rd_vld      <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
      if (cmd.bump) begin
        row_valid[slot_row] <= 1'b1;
        if (can_inc) begin
          count_total <= count_total + TOTAL_W'(1);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_bucket || cmd.emit_raw) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_bucket) begin
      out_low   <= sum[FIELD_W-1:0];
      out_high  <= FIELD_W'(sum + TOTAL_W'(cnt));
      out_total <= total_snap[FIELD_W-1:0];
      out_last  <= (sig == '0);
    end else if (cmd.emit_raw) begin
      out_low   <= FIELD_W'(rest & chunk_mask);
      out_high  <= FIELD_W'(rest & chunk_mask) + FIELD_W'(1);
      out_total <= FIELD_W'(1) << chunk;
      out_last  <= (left <= CHUNK_MAX);
    end
  end

endmodule

`default_nettype wire

FILE: design/adaptive_integer_interval_coder.sv
// ----------------------------------------------------------------------------
// Adaptive integer interval coder
// Front end of an adaptive-frequency arithmetic coder for signed integers:
// maps each value to a bucket, emits the bucket's cumulative interval and
// the raw bits below the leading bit for encode words, and tallies the bucket.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = opcode, s_tdata = value
// m_*       out  m_tvalid/m_tready  m_tdata = low, high, total; m_tlast = last
//
// One word is worked on at a time. After acceptance the controller finds the
// bucket, then scans the memory rows of four counts from the first up to the
// bucket's row (1 to 16 rows), updates the count and, for encode words, emits
// the intervals one at a time (up to 3), waiting while the output register
// holds a result not yet taken. Without stalls, the row scan takes the most time.
// Reset is synchronous and sets every count to one at once through per-row
// valid bits; no clearing pass is needed. A stalled m_tready holds the
// output register and the controller waits; s_tready is high only between
// words, and the last result may still wait in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_integer_interval_coder (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] value
  input  wire         s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata,   // [21:0] low, [43:22] high, [65:44] total, rest zero
  output logic        m_tlast
);
  import aiic_pkg::*;

  aiic_cmd_t    cmd;
  aiic_status_t status;

  logic [FIELD_W-1:0] out_low;
  logic [FIELD_W-1:0] out_high;
  logic [FIELD_W-1:0] out_total;

  // The controller only sequences; all storage and arithmetic sit in the
  // datapath.
  aiic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  aiic_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_opcode (s_tuser),
    .in_value  (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_low   (out_low),
    .out_high  (out_high),
    .out_total (out_total),
    .out_last  (m_tlast)
  );

  // The three bounds are packed from the lowest bit up, padded to whole bytes.
  assign m_tdata = {6'b0, out_total, out_high, out_low};

endmodule

`default_nettype wire

FILE: sim/aiic_interval_checker.sv
// ----------------------------------------------------------------------------
// Interval checker for the adaptive integer interval coder
// Watches both stream channels, keeps its own copy of the bucket counts,
// works out the intervals each accepted word must produce and compares them
// in order against the words leaving the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package aiic_op_pkg;
  import aiic_pkg::*;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_TALLY  = 1'b1
  } aiic_op_e;

  typedef struct packed {
    logic [FIELD_W-1:0] low;
    logic [FIELD_W-1:0] high;
    logic [FIELD_W-1:0] total;
    logic               last;
  } interval_t;
endpackage

module aiic_interval_checker
  import aiic_pkg::*;
  import aiic_op_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] value
  input  wire         s_tuser,   // [0] opcode
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [71:0] m_tdata,   // [21:0] low, [43:22] high, [65:44] total
  input  wire         m_tlast,
  output int          failures,
  output int          pending
);

  logic [COUNT_WIDTH-1:0] bucket_count [BUCKET_COUNT];
  logic [TOTAL_W-1:0]     bucket_sum;
  interval_t              interval_queue [$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic note_mismatch(input string what, input interval_t want, input interval_t got);
    failures++;
    // Fields are listed as low/high/total/last.
    $display("%0t: %s: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
             $time, what, want.low, want.high, want.total, want.last,
             got.low, got.high, got.total, got.last);
  endtask

  // Queue the intervals one word causes, then tally its bucket.
  task automatic predict_intervals(input aiic_op_e op, input logic [VALUE_W-1:0] value);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] part;
    logic [SIG_W-1:0]   sig;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] below;
    interval_t          iv;
    int                 b;
    int                 left;
    int                 c;
    neg = value[VALUE_W-1];
    mag = neg ? ~value : value;
    sig = '0;
    for (b = 0; b < 31; b++)
      if (mag[b]) sig = SIG_W'(b + 1);
    slot = {neg, sig};

    if (op == OP_ENCODE) begin
      below = '0;
      for (b = 0; b < int'(slot); b++)
        below = below + TOTAL_W'(bucket_count[b]);
      iv.low   = FIELD_W'(below);
      iv.high  = FIELD_W'(below + TOTAL_W'(bucket_count[slot]));
      iv.total = FIELD_W'(bucket_sum);
      iv.last  = (sig == 0);
      interval_queue = {interval_queue, iv};

      // Bits under the leading one go out as uniform chunks, lowest first.
      // A lone leading one still yields an empty chunk of width zero.
      if (sig != 0) begin
        left = int'(sig) - 1;
        rest = mag;
        do begin
          c     = (left > CHUNK_BITS) ? CHUNK_BITS : left;
          part  = rest & ((32'd1 << c) - 32'd1);
          rest  = rest >> c;
          left  = left - c;
          iv.low   = FIELD_W'(part);
          iv.high  = FIELD_W'(part + 32'd1);
          iv.total = FIELD_W'(32'd1 << c);
          iv.last  = (left == 0);
          interval_queue = {interval_queue, iv};
        end while (left > 0);
      end
    end

    // A saturated count stays put and leaves the sum alone.
    if (bucket_count[slot] != COUNT_LIMIT) begin
      bucket_count[slot] = bucket_count[slot] + 1'b1;
      bucket_sum         = bucket_sum + 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch
    interval_t got;
    interval_t want;
    int        i;
    if (rst) begin
      for (i = 0; i < BUCKET_COUNT; i++)
        bucket_count[i] = COUNT_WIDTH'(1);
      bucket_sum = TOTAL_W'(BUCKET_COUNT);
      interval_queue.delete();
    end else begin
      // Results first: a result leaving now belongs to an earlier word.
      if (m_tvalid && m_tready) begin
        got.low   = m_tdata[FIELD_W-1:0];
        got.high  = m_tdata[2*FIELD_W-1:FIELD_W];
        got.total = m_tdata[3*FIELD_W-1:2*FIELD_W];
        got.last  = m_tlast;
        if (interval_queue.size() == 0) begin
          want = '0;
          note_mismatch("unexpected interval", want, got);
        end else begin
          want = interval_queue.pop_front();
          if (got != want)
            note_mismatch("interval mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready)
        predict_intervals(aiic_op_e'(s_tuser), s_tdata);
    end
    pending <= interval_queue.size();
  end

endmodule

FILE: sim/tb_adaptive_integer_interval_coder.sv
// ----------------------------------------------------------------------------
// Testbench for the adaptive integer interval coder
// Drives directed and random words through the input stream under varying
// idle patterns on both sides, with a long output stall; the checker
// predicts and compares every interval.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_adaptive_integer_interval_coder;
  import aiic_op_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;

  int failures;
  int pending;

  // Idle rates in percent for the sender and the receiver.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  // Each raise of hold_asks makes the receiver stall for a long stretch.
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #6 clk = ~clk;

  adaptive_integer_interval_coder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  aiic_interval_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .failures (failures),
    .pending  (pending)
  );

  // Receiver: random back-pressure, or a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= 300;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offers one word, idling first at the sender's rate, and returns on the
  // edge where it is accepted.
  task automatic offer_word(input aiic_op_e op, input logic [31:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Random words: the significant-bit count is drawn evenly so that every
  // bucket and every chunk split shows up, with a share of raw 32-bit values.
  task automatic offer_random_words(input int n);
    logic [31:0] mag;
    logic [31:0] value;
    aiic_op_e    op;
    int          sig;
    int          k;
    for (k = 0; k < n; k++) begin
      op  = ($urandom_range(99) < 20) ? OP_TALLY : OP_ENCODE;
      sig = $urandom_range(31);
      if (sig == 0)
        mag = '0;
      else
        mag = (32'd1 << (sig - 1)) | ($urandom & ((32'd1 << (sig - 1)) - 32'd1));
      value = $urandom_range(1) ? ~mag : mag;
      if ($urandom_range(7) == 0)
        value = $urandom;
      offer_word(op, value);
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sender idles now and then, receiver more often.
    src_idle_pct  = 32;
    sink_idle_pct <= 56;

    // Directed words: zero and minus one, lone leading bits, the extremes,
    // chunk boundaries and alternating bit patterns.
    offer_word(OP_ENCODE, 32'h0000_0000);
    offer_word(OP_ENCODE, 32'hFFFF_FFFF);
    offer_word(OP_ENCODE, 32'h0000_0001);
    offer_word(OP_ENCODE, 32'hFFFF_FFFE);
    offer_word(OP_ENCODE, 32'h0000_0002);
    offer_word(OP_ENCODE, 32'h0000_0003);
    offer_word(OP_ENCODE, 32'h7FFF_FFFF);
    offer_word(OP_ENCODE, 32'h8000_0000);
    offer_word(OP_ENCODE, 32'h4000_0000);
    offer_word(OP_ENCODE, 32'hBFFF_FFFF);
    offer_word(OP_ENCODE, 32'h0000_8000);
    offer_word(OP_ENCODE, 32'h0001_0000);
    offer_word(OP_ENCODE, 32'h0001_FFFF);
    offer_word(OP_ENCODE, 32'h0002_0000);
    offer_word(OP_ENCODE, 32'hFFFD_FFFF);
    offer_word(OP_ENCODE, 32'h5555_5555);
    offer_word(OP_ENCODE, 32'hAAAA_AAAA);
    offer_word(OP_TALLY,  32'h0000_0005);
    offer_word(OP_TALLY,  32'hFFFF_FFF9);
    offer_word(OP_TALLY,  32'h8000_0000);
    offer_word(OP_ENCODE, 32'h0000_0005);
    offer_word(OP_ENCODE, 32'hFFFF_FFF9);
    offer_word(OP_ENCODE, 32'h7FFF_FFFF);

    offer_random_words(100);

    // The other way round: receiver mostly ready, sender often idle.
    src_idle_pct  = 56;
    sink_idle_pct <= 32;
    offer_random_words(100);

    // Neither side idles; partway through the receiver holds off while the
    // sender keeps offering, so the block backs up and drops s_tready.
    src_idle_pct  = 0;
    sink_idle_pct <= 0;
    offer_random_words(60);
    hold_asks <= hold_asks + 1;
    offer_random_words(70);

    // A few directed words around the lowest and highest buckets to finish.
    offer_word(OP_ENCODE, 32'h0000_0000);
    offer_word(OP_ENCODE, 32'h0000_0001);
    offer_word(OP_ENCODE, 32'hFFFF_FFFF);
    offer_word(OP_ENCODE, 32'h8000_0000);
    offer_word(OP_ENCODE, 32'h0000_0000);
    s_tvalid <= 1'b0;

    // Let the last word's intervals drain, then allow for a trailing tally.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (failures == 0)
      $display("PASS adaptive_integer_interval_coder");
    else
      $display("FAIL adaptive_integer_interval_coder");
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL adaptive_integer_interval_coder");
    $finish;
  end

endmodule
